>>> sv/bal_pkg.sv
// Shared types and constants for the buddy allocator.
package bal_pkg;

    typedef enum logic [1:0] {
        STATUS_ALLOC = 2'd0,
        STATUS_FAIL  = 2'd1,
        STATUS_FREED = 2'd2
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam int REQ_W = 16;
    localparam int OFF_W = 12;
    localparam int LVL_W = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT,
        ST_FREE_SET,
        ST_MRG_RD,
        ST_MRG_CHK,
        ST_MRG_CLR,
        ST_DONE
    } state_t;

endpackage

>>> sv/bal_map_mem.sv
// Free-bit map memory: one port for read and write, registered read data.
module bal_map_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic          wdata,
    output logic          rdata
);
    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/buddy_allocator.sv
// Buddy allocator top level: control sequencer around the free-bit map memory.
// Free bits sit in one single-port memory of 2^LEVELS entries, one bit each.
// After reset a clearing pass over all 2^LEVELS entries runs while s_tready stays low.
// Allocate: the scan reads and checks each block visited (up to 2^LEVELS - 1 of them),
// then splits one level at a time; free: set, read the buddy, clear both per merge.
// A done state follows; the result waits in a register and blocks input until taken.
module buddy_allocator #(
    parameter int LEVELS    = 8,
    parameter int MIN_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // command[0], request_bytes[16:1], block_offset[28:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // status[1:0], result_offset[13:2], result_level[16:14]
);
    import bal_pkg::*;

    localparam int AW    = LEVELS;
    localparam int DEPTH = 1 << LEVELS;
    localparam int LW    = $clog2(LEVELS + 1);
    localparam int MINSH = $clog2(MIN_BYTES);

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic          clr_busy_reg;
    logic          cmd_reg;
    logic [LW-1:0] k_reg, k_next, lvl_reg, lvl_next;
    logic [AW-1:0] blk_reg, blk_next;
    logic [1:0]    st_reg;
    logic [OFF_W-1:0] ro_reg;
    logic [LVL_W-1:0] rl_reg;
    logic          mv_reg;

    logic          we;
    logic [AW-1:0] addr;
    logic          wdata;
    logic          rdata;

    logic [REQ_W-1:0] in_req;
    logic [OFF_W-1:0] in_off;
    logic [LW-1:0]    in_k;
    logic             done;

    assign in_req = s_tdata[16:1];
    assign in_off = s_tdata[28:17];

    function automatic logic [AW-1:0] idx(input logic [LW-1:0] l, input logic [AW-1:0] b);
        logic [AW-1:0] cnt;
        cnt = AW'((1 << (LEVELS - 1)) >> l);
        return (cnt - AW'(1)) + (b & (cnt - AW'(1)));
    endfunction

    always_comb begin
        in_k = LW'(LEVELS);
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if ({16'd0, in_req} <= (32'(MIN_BYTES) << i)) begin
                in_k = LW'(i);
            end
        end
    end

    bal_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk (aclk), .we (we), .addr (addr), .wdata (wdata), .rdata (rdata)
    );

    assign s_tready = (state_reg == ST_IDLE) && !clr_busy_reg && !mv_reg;
    assign done = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        k_next = k_reg;
        lvl_next = lvl_reg;
        blk_next = blk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    k_next = in_k;
                    lvl_next = in_k;
                    blk_next = AW'((32'(in_off) >> MINSH) >> in_k);
                    if (in_k >= LW'(LEVELS)) begin
                        state_next = ST_DONE;
                    end else if (s_tdata[0] == CMD_ALLOC) begin
                        blk_next = '0;
                        state_next = ST_SCAN_RD;
                    end else begin
                        state_next = ST_FREE_SET;
                    end
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (rdata) begin
                    state_next = (lvl_reg == k_reg) ? ST_DONE : ST_SPLIT;
                end else if (blk_reg == AW'(((1 << (LEVELS - 1)) >> lvl_reg) - 1)) begin
                    blk_next = '0;
                    lvl_next = lvl_reg + LW'(1);
                    state_next = (lvl_reg == LW'(LEVELS - 1)) ? ST_DONE : ST_SCAN_RD;
                end else begin
                    blk_next = blk_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SPLIT: begin
                lvl_next = lvl_reg - LW'(1);
                blk_next = blk_reg << 1;
                if (lvl_reg - LW'(1) == k_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE_SET: begin
                state_next = (lvl_reg == LW'(LEVELS - 1)) ? ST_DONE : ST_MRG_RD;
            end
            ST_MRG_RD: state_next = ST_MRG_CHK;
            ST_MRG_CHK: state_next = rdata ? ST_MRG_CLR : ST_DONE;
            ST_MRG_CLR: begin
                blk_next = blk_reg >> 1;
                lvl_next = lvl_reg + LW'(1);
                state_next = ST_FREE_SET;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        wdata = 1'b0;
        addr = idx(lvl_reg, blk_reg);
        if (clr_busy_reg) begin
            we = 1'b1;
            addr = clr_reg;
            wdata = (clr_reg == '0);
        end else begin
            case (state_reg)
                ST_SCAN_CHK: begin
                    we = rdata;
                end
                ST_SPLIT: begin
                    we = 1'b1;
                    wdata = 1'b1;
                    addr = idx(lvl_reg - LW'(1), (blk_reg << 1) | AW'(1));
                end
                ST_FREE_SET: begin
                    we = 1'b1;
                    wdata = 1'b1;
                end
                ST_MRG_RD, ST_MRG_CHK: begin
                    addr = idx(lvl_reg, blk_reg ^ AW'(1));
                    we = (state_reg == ST_MRG_CHK) && rdata;
                end
                ST_MRG_CLR: begin
                    we = 1'b1;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg <= '0;
            clr_busy_reg <= 1'b1;
            mv_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                mv_reg <= 1'b0;
            end
            if (done) begin
                mv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        blk_reg <= blk_next;
        lvl_reg <= lvl_next;
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tdata[0];
        end
        if (done) begin
            if (k_reg >= LW'(LEVELS) || (cmd_reg == CMD_ALLOC && lvl_reg >= LW'(LEVELS))) begin
                st_reg <= STATUS_FAIL;
                ro_reg <= '0;
                rl_reg <= '0;
            end else begin
                st_reg <= (cmd_reg == CMD_ALLOC) ? STATUS_ALLOC : STATUS_FREED;
                ro_reg <= OFF_W'((32'(blk_reg) << lvl_reg) << MINSH);
                rl_reg <= LVL_W'(lvl_reg);
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, rl_reg, ro_reg, st_reg};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE && !m_tvalid))
        else $error("input taken while busy");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("bad status code");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_tvalid)
        else $error("result lost");

endmodule
